>>> rtl/lru_block_buffer_cache_macros.svh
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_macros
// assertion macros for the buffer cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_MACROS_SVH
`define LRU_BLOCK_BUFFER_CACHE_MACROS_SVH

// plain check, clocked, off during reset
`define LBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that applies only while a result is offered
`define LBC_ASSERT_OUT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) m_axis_tvalid |-> prop) \
		else $error(msg);

`endif

>>> rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// types and codes shared by the buffer cache modules
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int DEV_W   = 8;
	localparam int BLK_W   = 32;
	localparam int TAG_W   = DEV_W + BLK_W;
	localparam int SLOT_W  = 5;
	localparam int CNT_W   = 8;
	localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

	typedef enum logic [1:0] {
		REQ_ACQUIRE = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_PIN     = 2'd2,
		REQ_UNPIN   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_UNDER   = 2'd2,
		ST_OVER    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic load_req;
		logic scan_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/lru_block_buffer_cache.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// lru buffer cache with per-slot reference counts
// ----------------------------------------------------------------------------
// One request at a time. An acquire walks the tag ram one slot per cycle,
// then drains and commits; release, pin and unpin skip the scan and go
// straight to commit. A new request is taken while the previous result still
// waits in the output register. Recency is kept as a rank per slot (0 = most
// recent); a hit picks the matching slot of lowest rank, a miss the free slot
// of highest rank.
module lru_block_buffer_cache #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // device_id, block_number, slot_index, zero pad
	input  logic [1:0]  s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // slot_out, was_hit, needs_read, status, zero pad
);
	import lbc_pkg::*;

	`include "lru_block_buffer_cache_macros.svh"

	cmd_t cmd;
	sts_t sts;

	logic [SLOT_W-1:0] out_slot;
	logic              out_hit, out_rd;
	logic [1:0]        out_status;

	lbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_kind  (s_axis_tuser),
		.req_ready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lbc_dp #(.NUM_BUFFERS(NUM_BUFFERS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_kind    (s_axis_tuser),
		.in_dev     (s_axis_tdata[7:0]),
		.in_blk     (s_axis_tdata[39:8]),
		.in_slot    (s_axis_tdata[44:40]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_slot   (out_slot),
		.out_hit    (out_hit),
		.out_rd     (out_rd),
		.out_status (out_status)
	);

	assign m_axis_tdata = {7'b0, out_status, out_rd, out_hit, out_slot};

	// busy after each accepted request
	`LBC_ASSERT(a_busy_after_req, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request taken while busy")
	// needs_read only on a good grant
	`LBC_ASSERT_OUT(a_rd_ok, !m_axis_tdata[6] || m_axis_tdata[8:7] == ST_OK, "needs_read with error status")
	// no free slot reports slot zero, no hit
	`LBC_ASSERT_OUT(a_nofree, m_axis_tdata[8:7] != ST_NO_FREE || m_axis_tdata[5:0] == 6'd0, "bad no-free result")
	// underflow never reports a hit
	`LBC_ASSERT_OUT(a_under, m_axis_tdata[8:7] != ST_UNDER || !m_axis_tdata[5], "hit on underflow")

endmodule

>>> rtl/lbc_ram.sv
// ----------------------------------------------------------------------------
// lbc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/lbc_ctrl.sv
// ----------------------------------------------------------------------------
// lbc_ctrl
// request sequencer: accept, tag scan, drain, commit
// ----------------------------------------------------------------------------
module lbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    req_kind,
	output logic          req_ready,
	input  lbc_pkg::sts_t sts,
	output lbc_pkg::cmd_t cmd
);
	import lbc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d = (req_t'(req_kind) == REQ_ACQUIRE) ? S_SCAN : S_COMMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/lbc_dp.sv
// ----------------------------------------------------------------------------
// lbc_dp
// slot state, tag ram, recency ranks, search and result register
// ----------------------------------------------------------------------------
module lbc_dp #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lbc_pkg::cmd_t                cmd,
	output lbc_pkg::sts_t                sts,
	input  logic [1:0]                   in_kind,
	input  logic [lbc_pkg::DEV_W-1:0]    in_dev,
	input  logic [lbc_pkg::BLK_W-1:0]    in_blk,
	input  logic [lbc_pkg::SLOT_W-1:0]   in_slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lbc_pkg::SLOT_W-1:0]   out_slot,
	output logic                         out_hit,
	output logic                         out_rd,
	output logic [1:0]                   out_status
);
	import lbc_pkg::*;

	localparam int W = $clog2(NUM_BUFFERS);

	req_t             req_q;
	logic [DEV_W-1:0] dev_q;
	logic [BLK_W-1:0] blk_q;
	logic [SLOT_W-1:0] slot_q;

	logic [CNT_W-1:0] ref_q   [NUM_BUFFERS];
	logic [W-1:0]     rank_q  [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] cv_q;
	logic [NUM_BUFFERS-1:0] tag_ok_q;

	logic [W-1:0] cnt_q;
	logic [W-1:0] addr_s1;
	logic         valid_s1;

	logic         hit_found_q, free_found_q;
	logic [W-1:0] hit_slot_q, free_slot_q, hit_rank_q, free_rank_q;

	logic             tag_we;
	logic [TAG_W-1:0] tag_rdata, tag_cur;
	logic [W-1:0]     cs;
	logic [W-1:0]     ridx;
	logic [CNT_W-1:0] ref_r;
	logic [W-1:0]     rank_r;
	logic             match;
	logic             in_range;

	logic             upd_ref, mark_cv, move_front;
	logic [CNT_W-1:0] ref_new;
	logic [SLOT_W-1:0] res_slot;
	logic             res_hit, res_rd;
	status_t          res_st;

	lbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_BUFFERS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (free_slot_q),
		.wdata ({blk_q, dev_q}),
		.raddr (cnt_q),
		.rdata (tag_rdata)
	);

	assign sts.scan_last = (cnt_q == W'(NUM_BUFFERS - 1));
	assign sts.out_free  = !out_valid || out_ready;

	assign cs       = (req_q == REQ_ACQUIRE) ? (hit_found_q ? hit_slot_q : free_slot_q)
	                                         : W'(slot_q);
	assign in_range = (32'(slot_q) < 32'(NUM_BUFFERS));
	assign ridx     = cmd.commit ? cs : addr_s1;
	assign ref_r    = ref_q[ridx];
	assign rank_r   = rank_q[ridx];
	assign tag_cur  = tag_ok_q[addr_s1] ? tag_rdata : '0;
	assign match    = (tag_cur == {blk_q, dev_q});

	always_comb begin
		tag_we     = 1'b0;
		upd_ref    = 1'b0;
		mark_cv    = 1'b0;
		move_front = 1'b0;
		ref_new    = ref_r;
		res_slot   = slot_q;
		res_hit    = 1'b0;
		res_rd     = 1'b0;
		res_st     = ST_OK;
		case (req_q)
			REQ_ACQUIRE: begin
				res_slot = SLOT_W'(cs);
				if (hit_found_q) begin
					res_hit = 1'b1;
					if (ref_r == COUNT_MAX) begin
						res_st = ST_OVER;
					end else begin
						upd_ref = 1'b1;
						ref_new = ref_r + 1'b1;
						mark_cv = 1'b1;
						res_rd  = !cv_q[cs];
					end
				end else if (free_found_q) begin
					tag_we  = cmd.commit;
					upd_ref = 1'b1;
					ref_new = CNT_W'(1);
					mark_cv = 1'b1;
					res_rd  = 1'b1;
				end else begin
					res_slot = '0;
					res_st   = ST_NO_FREE;
				end
			end
			REQ_PIN: begin
				if (in_range) begin
					if (ref_r == COUNT_MAX) begin
						res_st = ST_OVER;
					end else begin
						upd_ref = 1'b1;
						ref_new = ref_r + 1'b1;
					end
				end
			end
			REQ_RELEASE, REQ_UNPIN: begin
				if (in_range) begin
					if (ref_r == '0) begin
						res_st = ST_UNDER;
					end else begin
						upd_ref    = 1'b1;
						ref_new    = ref_r - 1'b1;
						move_front = (req_q == REQ_RELEASE) && (ref_r == CNT_W'(1));
					end
				end
			end
			default: begin
				res_st = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q  <= req_t'(in_kind);
			dev_q  <= in_dev;
			blk_q  <= in_blk;
			slot_q <= in_slot;
		end
		if (cmd.scan_step) begin
			addr_s1 <= cnt_q;
		end
		if (valid_s1) begin
			if (match && (!hit_found_q || rank_r < hit_rank_q)) begin
				hit_slot_q <= addr_s1;
				hit_rank_q <= rank_r;
			end
			if (ref_r == '0 && (!free_found_q || rank_r > free_rank_q)) begin
				free_slot_q <= addr_s1;
				free_rank_q <= rank_r;
			end
		end
		if (cmd.commit) begin
			out_slot   <= res_slot;
			out_hit    <= res_hit;
			out_rd     <= res_rd;
			out_status <= res_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			valid_s1     <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			out_valid    <= 1'b0;
			cv_q         <= '0;
			tag_ok_q     <= '0;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				ref_q[i]  <= '0;
				rank_q[i] <= W'(NUM_BUFFERS - 1 - i);
			end
		end else begin
			valid_s1 <= cmd.scan_step;
			if (cmd.load_req) begin
				cnt_q        <= '0;
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (cmd.scan_step && !sts.scan_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (valid_s1) begin
				if (match) begin
					hit_found_q <= 1'b1;
				end
				if (ref_r == '0) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid <= 1'b1;
				if (upd_ref) begin
					ref_q[cs] <= ref_new;
				end
				if (mark_cv) begin
					cv_q[cs] <= 1'b1;
				end
				if (tag_we) begin
					tag_ok_q[cs] <= 1'b1;
				end
				if (move_front) begin
					for (int i = 0; i < NUM_BUFFERS; i++) begin
						if (rank_q[i] < rank_r) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					rank_q[cs] <= '0;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule
